// ----- rtl/core/lwd_pkg.sv -----
// Shared types and constants for the layered logical watchdog.
`timescale 1ns / 1ps
package lwd_pkg;

	localparam int LAYERS    = 3;
	localparam int LAYER_W   = 3;
	localparam int MS_W      = 13;
	localparam int LIMIT_W   = 23;
	localparam int TIME_W    = 32;
	localparam int FAULT_W   = 2;

	localparam logic [MS_W-1:0]    DEFAULT_MS = MS_W'(200);
	localparam logic [9:0]         US_PER_MS  = 10'd1000;
	localparam logic [LAYER_W-1:0] LAYER_CNT  = LAYER_W'(LAYERS);
	localparam logic [FAULT_W-1:0] NO_FAULT   = 2'd3;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_FEED  = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic               wr_all;
		logic               wr_one;
		logic [LAYER_W-1:0] layer;
		logic [TIME_W-1:0]  now_us;
		logic [LIMIT_W-1:0] limit;
	} lwd_cmd_t;

	// Handed from cell to cell: first expired layer found so far.
	typedef struct packed {
		logic               hit;
		logic [FAULT_W-1:0] idx;
	} lwd_chain_t;

	typedef struct packed {
		logic               hw_kick;
		logic               reset_request;
		logic [FAULT_W-1:0] fault_layer;
		logic               bad_feed;
		logic               armed;
	} lwd_res_t;

endpackage

// ----- rtl/core/lwd_cell.sv -----
// One layer cell: holds the layer's stamp and checks its age against the limit.
`timescale 1ns / 1ps
module lwd_cell import lwd_pkg::*; (
	input  logic               clk,
	input  logic [LAYER_W-1:0] cell_idx,
	input  lwd_cmd_t           cmd,
	input  lwd_chain_t         chain_in,
	output lwd_chain_t         chain_out
);

	logic [TIME_W-1:0] stamp_q;
	logic [TIME_W-1:0] age;
	logic              expired;
	logic              wr_en;

	assign wr_en   = cmd.wr_all | (cmd.wr_one && (cmd.layer == cell_idx));
	assign age     = cmd.now_us - stamp_q;
	assign expired = age > {{(TIME_W-LIMIT_W){1'b0}}, cmd.limit};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_q <= cmd.now_us;
		end
	end

	// Keep the lower layer's hit; otherwise offer this one.
	always_comb begin
		if (chain_in.hit) begin
			chain_out = chain_in;
		end else begin
			chain_out.hit = expired;
			chain_out.idx = cell_idx[FAULT_W-1:0];
		end
	end

endmodule

// ----- rtl/core/lwd_out_buf.sv -----
// Two-entry skid buffer on the result side.
`timescale 1ns / 1ps
module lwd_out_buf import lwd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  lwd_res_t push_data,
	output logic     push_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output lwd_res_t out_data
);

	logic     main_v_q;
	logic     skid_v_q;
	lwd_res_t main_q;
	lwd_res_t skid_q;
	logic     pop;
	logic     load_main;

	assign pop        = main_v_q & out_ready;
	assign load_main  = !main_v_q || pop;
	assign push_ready = !skid_v_q;
	assign out_valid  = main_v_q;
	assign out_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_main) begin
				main_v_q <= skid_v_q | push;
				skid_v_q <= skid_v_q & push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Drain the skid word first so order is kept.
	always_ff @(posedge clk) begin
		if (load_main) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- rtl/core/layered_logical_watchdog_unit.sv -----
// Top level of the layered logical watchdog: control, layer cell row and result buffer.
//
//  channel  handshake              word
//  cfg      cfg_valid / cfg_ready  tmo_ms
//  in       in_valid / in_ready    req_type, layer, now_us, suspended
//  out      out_valid / out_ready  hw_kick, reset_request, fault_layer, bad_feed, armed
//
// One word is accepted per cycle unless in_ready is low; its result is registered.
// All layer cells compare in parallel in the accept cycle, so state is ready for the next word.
// The timeout in microseconds is multiplied out when tmo_ms is written.
// Reset disarms, clears the fault layer to none and sets a 200 ms timeout.
// A stalled output fills a two-word skid buffer before in_ready drops.
`timescale 1ns / 1ps
module layered_logical_watchdog_unit import lwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [MS_W-1:0]    tmo_ms,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [LAYER_W-1:0] layer,
	input  logic [TIME_W-1:0]  now_us,
	input  logic               suspended,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hw_kick,
	output logic               reset_request,
	output logic [FAULT_W-1:0] fault_layer,
	output logic               bad_feed,
	output logic               armed
);

	logic               armed_q;
	logic [FAULT_W-1:0] fault_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [MS_W-1:0]    eff_ms;
	logic               accept;
	req_t               req;
	logic               is_start;
	logic               is_feed;
	logic               is_tick;
	logic               timeout;
	lwd_cmd_t           cmd;
	lwd_chain_t         chain [LAYERS+1];
	lwd_res_t           res;
	lwd_res_t           out_data;

	assign cfg_ready = 1'b1;
	assign eff_ms    = (tmo_ms == '0) ? DEFAULT_MS : tmo_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(DEFAULT_MS) * LIMIT_W'(US_PER_MS);
		end else if (cfg_valid) begin
			limit_q <= LIMIT_W'(eff_ms) * LIMIT_W'(US_PER_MS);
		end
	end

	assign accept   = in_valid & in_ready;
	assign req      = req_t'(req_type);
	assign is_start = (req == REQ_START);
	assign is_feed  = (req == REQ_FEED) && armed_q;
	assign is_tick  = (req == REQ_TICK) && armed_q;

	assign cmd.wr_all = accept && is_start;
	assign cmd.wr_one = accept && is_feed;
	assign cmd.layer  = layer;
	assign cmd.now_us = now_us;
	assign cmd.limit  = limit_q;

	assign chain[0] = '0;

	for (genvar i = 0; i < LAYERS; i++) begin : g_cell
		lwd_cell u_cell (
			.clk       (clk),
			.cell_idx  (LAYER_W'(i)),
			.cmd       (cmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign timeout = is_tick && !suspended && chain[LAYERS].hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			fault_q <= NO_FAULT;
		end else if (accept) begin
			if (is_start) begin
				armed_q <= 1'b1;
			end else if (timeout) begin
				armed_q <= 1'b0;
				fault_q <= chain[LAYERS].idx;
			end
		end
	end

	always_comb begin
		res.hw_kick       = is_tick && (suspended || !chain[LAYERS].hit);
		res.reset_request = timeout;
		res.fault_layer   = timeout ? chain[LAYERS].idx : fault_q;
		res.bad_feed      = is_feed && (layer >= LAYER_CNT);
		res.armed         = is_start || (armed_q && !timeout);
	end

	lwd_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (res),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign hw_kick       = out_data.hw_kick;
	assign reset_request = out_data.reset_request;
	assign fault_layer   = out_data.fault_layer;
	assign bad_feed      = out_data.bad_feed;
	assign armed         = out_data.armed;

endmodule

// ----- verif/tb_layered_logical_watchdog_unit.sv -----
// Testbench for the layered logical watchdog: directed and random words against a predictor.
`timescale 1ns / 1ps

import lwd_pkg::*;

class watchdog_scoreboard;
	logic [TIME_W-1:0]  stamps [LAYERS];
	bit                 armed_st;
	logic [FAULT_W-1:0] fault_st;
	logic [MS_W-1:0]    ms_st;
	lwd_res_t           due_results [$];
	int                 errors;

	function new();
		foreach (stamps[i]) stamps[i] = '0;
		armed_st = 1'b0;
		fault_st = NO_FAULT;
		ms_st    = '0;
		errors   = 0;
	endfunction

	function void set_timeout(logic [MS_W-1:0] ms);
		ms_st = ms;
	endfunction

	function int unsigned limit_us();
		int unsigned ms;
		ms = (ms_st == '0) ? 200 : int'(ms_st);
		return ms * 1000;
	endfunction

	// Predict the result of one accepted word and queue it.
	function void note_word(req_t rq, logic [LAYER_W-1:0] ly, logic [TIME_W-1:0] nw, logic sp);
		lwd_res_t          r;
		logic [TIME_W-1:0] age;
		int unsigned       lim;
		int                hit_at;
		r = '0;
		hit_at = -1;
		lim = limit_us();
		case (rq)
			REQ_START: begin
				foreach (stamps[i]) stamps[i] = nw;
				armed_st = 1'b1;
			end
			REQ_FEED: begin
				if (armed_st) begin
					if (ly < LAYERS)
						stamps[ly] = nw;
					else
						r.bad_feed = 1'b1;
				end
			end
			REQ_TICK: begin
				if (armed_st) begin
					if (sp) begin
						r.hw_kick = 1'b1;
					end else begin
						// walk downwards so the lowest expired layer wins
						for (int i = LAYERS - 1; i >= 0; i--) begin
							age = nw - stamps[i];
							if (age > lim)
								hit_at = i;
						end
						if (hit_at >= 0) begin
							fault_st = FAULT_W'(hit_at);
							armed_st = 1'b0;
							r.reset_request = 1'b1;
						end else begin
							r.hw_kick = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		r.fault_layer = fault_st;
		r.armed = armed_st;
		due_results.push_back(r);
	endfunction

	function void check_field(string name, int unsigned e, int unsigned g);
		if (e != g) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, g);
			errors++;
		end
	endfunction

	function void check_result(lwd_res_t got);
		lwd_res_t e;
		if (due_results.size() == 0) begin
			$display("%0t: result with nothing due, expected none, actual %b", $time, got);
			errors++;
			return;
		end
		e = due_results.pop_front();
		check_field("hw_kick", e.hw_kick, got.hw_kick);
		check_field("reset_request", e.reset_request, got.reset_request);
		check_field("fault_layer", e.fault_layer, got.fault_layer);
		check_field("bad_feed", e.bad_feed, got.bad_feed);
		check_field("armed", e.armed, got.armed);
	endfunction
endclass

module tb_layered_logical_watchdog_unit;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_WORDS  = 138;
	localparam int LONG_HOLD    = 160;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [MS_W-1:0]    tmo_ms = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type = REQ_NOP;
	logic [LAYER_W-1:0] layer = '0;
	logic [TIME_W-1:0]  now_us = '0;
	logic               suspended = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               hw_kick;
	logic               reset_request;
	logic [FAULT_W-1:0] fault_layer;
	logic               bad_feed;
	logic               armed;

	watchdog_scoreboard sb;
	int                 gap_pct = 0;
	int                 stall_pct = 0;
	int                 hold_reqs = 0;
	int                 hold_done = 0;
	int                 hold_left = 0;
	int                 cycles = 0;
	int unsigned        cur_lim = 200000;
	logic [TIME_W-1:0]  t_now = '0;

	layered_logical_watchdog_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.tmo_ms        (tmo_ms),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.layer         (layer),
		.now_us        (now_us),
		.suspended     (suspended),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hw_kick       (hw_kick),
		.reset_request (reset_request),
		.fault_layer   (fault_layer),
		.bad_feed      (bad_feed),
		.armed         (armed)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Sample between edges; every handshake seen here completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_timeout(tmo_ms);
			if (in_valid && in_ready)
				sb.note_word(req_t'(req_type), layer, now_us, suspended);
			if (out_valid && out_ready)
				sb.check_result({hw_kick, reset_request, fault_layer, bad_feed, armed});
		end
	end

	// Called just after a rising edge; returns at the edge that takes the word.
	task automatic send_word(input req_t rq, input logic [LAYER_W-1:0] ly,
			input logic [TIME_W-1:0] nw, input logic sp);
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= rq;
		layer     <= ly;
		now_us    <= nw;
		suspended <= sp;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic write_timeout(input logic [MS_W-1:0] ms);
		cfg_valid <= 1'b1;
		tmo_ms    <= ms;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		cur_lim = ((ms == '0) ? 200 : int'(ms)) * 1000;
	endtask

	// Drop valid and wait until every result is home.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [TIME_W-1:0]  base;
		logic [MS_W-1:0]    phase_ms [4];
		req_t               rq;
		logic [LAYER_W-1:0] ly;
		logic [TIME_W-1:0]  nw;
		logic               sp;
		int                 pick;
		int                 s;

		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset timeout of 200 ms.
		base = 32'hFFFF_FF00;
		send_word(REQ_TICK, 3'd0, 32'hFFFF_FFFF, 1'b0);    // not armed
		send_word(REQ_FEED, 3'd7, 32'h0, 1'b0);            // not armed, no bad flag
		send_word(REQ_NOP, 3'd0, 32'h0, 1'b0);
		send_word(REQ_START, 3'd0, base, 1'b0);
		send_word(REQ_TICK, 3'd0, 32'h0000_0100, 1'b0);    // age wraps past zero
		send_word(REQ_TICK, 3'd0, base + 32'd200000, 1'b0); // age equals limit
		send_word(REQ_FEED, 3'd0, base + 32'd100000, 1'b0);
		send_word(REQ_FEED, 3'd3, 32'h0, 1'b1);            // first index out of range
		send_word(REQ_FEED, 3'd7, 32'hFFFF_FFFF, 1'b0);
		send_word(REQ_TICK, 3'd2, 32'h7FFF_FFFF, 1'b1);    // suspended, kick regardless
		send_word(REQ_NOP, 3'd7, 32'hFFFF_FFFF, 1'b1);
		send_word(REQ_TICK, 3'd0, base + 32'd200001, 1'b0); // layer 1 expires
		send_word(REQ_TICK, 3'd0, base + 32'd200001, 1'b0); // halted
		send_word(REQ_FEED, 3'd1, 32'h0, 1'b0);            // halted
		send_word(REQ_START, 3'd0, 32'h0, 1'b0);           // fault layer kept
		send_word(REQ_FEED, 3'd0, 32'd150000, 1'b0);
		send_word(REQ_FEED, 3'd1, 32'd150000, 1'b0);
		send_word(REQ_TICK, 3'd0, 32'd200001, 1'b0);       // layer 2 expires
		send_word(REQ_START, 3'd0, 32'h1234_5678, 1'b0);
		send_word(REQ_TICK, 3'd0, 32'h1234_5677, 1'b0);    // maximum age, layer 0
		send_word(REQ_START, 3'd5, 32'hFFFF_FFFF, 1'b1);
		send_word(REQ_TICK, 3'd0, 32'h0000_0000, 1'b0);

		phase_ms[0] = MS_W'(1);
		phase_ms[1] = '0;
		phase_ms[2] = {MS_W{1'b1}};
		phase_ms[3] = MS_W'($urandom_range(2, 8190));
		t_now = $urandom;

		for (int p = 0; p < 4; p++) begin
			drain();
			case (p)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 48; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 48; end
				default: begin gap_pct = 22; stall_pct = 22; end
			endcase
			write_timeout(phase_ms[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// hold the receiver off while words keep coming, to fill the buffer
				if (p == 0 && n == 40)
					hold_reqs++;
				pick = $urandom_range(0, 99);
				ly = ($urandom_range(0, 99) < 85) ? LAYER_W'($urandom_range(0, LAYERS - 1))
						: LAYER_W'($urandom_range(LAYERS, 7));
				sp = ($urandom_range(0, 99) < 15);
				s = $urandom_range(0, 99);
				if (s < 70)
					t_now = t_now + $urandom_range(0, cur_lim / 16);
				else if (s < 90)
					t_now = t_now + $urandom_range(cur_lim / 8, cur_lim / 4);
				else if (s < 97)
					t_now = t_now + $urandom_range(cur_lim, cur_lim + 2);
				else
					t_now = $urandom;
				if (!sb.armed_st && pick < 70)
					rq = REQ_START;
				else if (pick < 6)
					rq = REQ_START;
				else if (pick < 42)
					rq = REQ_FEED;
				else if (pick < 92)
					rq = REQ_TICK;
				else
					rq = req_t'($urandom_range(0, 3));
				nw = t_now;
				// aim some ticks right at the edge of one layer's timeout
				if (rq == REQ_TICK && $urandom_range(0, 99) < 15)
					nw = sb.stamps[$urandom_range(0, LAYERS - 1)] + cur_lim
							+ $urandom_range(0, 1);
				send_word(rq, ly, nw, sp);
			end
		end

		drain();
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
